### design/hab_pkg.sv
// ============================================================================
// hab_pkg: shared types, constants and arithmetic helpers
// Number formats, CORDIC tables, scaling constants and the fixed-point
// multiply helpers used by the helicity angular basis pipeline.
// ============================================================================
package hab_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SQ_BITS   = FRAC_BITS + 1;
    localparam int VAL_W     = 24;
    localparam int COEF_W    = 31;

    typedef logic signed [17:0]       cos_t;
    typedef logic signed [15:0]       ang_t;
    typedef logic [3:0]               mode_t;
    typedef logic [SQ_BITS-1:0]       sin_t;
    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic [COEF_W-1:0]        coef_t;

    typedef struct packed {
        cos_t  cos_kaon;
        cos_t  cos_muon;
        ang_t  azimuth;
        mode_t mode;
    } evt_t;

    typedef struct packed {
        logic  v;
        mode_t mode;
        cos_t  ck;
        cos_t  cl;
        sin_t  sk;
        sin_t  sl;
        cos_t  cp;
        cos_t  sp;
    } trig_t;

    localparam mode_t TERM_1  = 4'd1;
    localparam mode_t TERM_2  = 4'd2;
    localparam mode_t TERM_3  = 4'd3;
    localparam mode_t TERM_4  = 4'd4;
    localparam mode_t TERM_5  = 4'd5;
    localparam mode_t TERM_6  = 4'd6;
    localparam mode_t TERM_7  = 4'd7;
    localparam mode_t TERM_8  = 4'd8;
    localparam mode_t TERM_9  = 4'd9;
    localparam mode_t TERM_10 = 4'd10;

    localparam coef_t K_SQRT2  = 31'd1518500250;
    localparam coef_t K_2SQRT6 = 31'd876706528;
    localparam coef_t K_2SQRT3 = 31'd1239850262;
    localparam coef_t K_THIRD  = 31'd357913941;
    localparam coef_t K_HALF   = 31'd536870912;
    localparam coef_t K_UNITY  = 31'd1073741824;

    localparam val_t ONE_V = val_t'(1 << FRAC_BITS);

    localparam logic [30:0] ATAN_TAB [32] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
        31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
        31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
        31'd166886,    31'd83443,     31'd41722,     31'd20861,
        31'd10430,     31'd5215,      31'd2608,      31'd1304,
        31'd652,       31'd326,       31'd163,       31'd81,
        31'd41,        31'd20,        31'd10,        31'd5,
        31'd3,         31'd1,         31'd1,         31'd0
    };

    // Square root of the CORDIC gain product, evaluated at elaboration.
    function automatic longint unsigned gain_root(input int steps);
        longint unsigned p;
        longint unsigned n;
        longint unsigned res;
        longint unsigned bit_v;
        p = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (i < steps) begin
                p = p + (p >> (2 * i));
            end
        end
        n = p;
        res = 64'd0;
        bit_v = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= res + bit_v) begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic val_t mul(input val_t a, input val_t b);
        logic signed [2*VAL_W-1:0] p;
        p = a * b;
        p = p + ((2*VAL_W)'(1) <<< (FRAC_BITS - 1));
        return val_t'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [VAL_W+COEF_W:0] mulc(input val_t a, input coef_t c);
        logic signed [VAL_W+COEF_W:0] p;
        p = a * $signed({1'b0, c});
        p = p + ((VAL_W+COEF_W+1)'(1) <<< 29);
        return p >>> 30;
    endfunction

endpackage

### design/hab_evt_if.sv
// ============================================================================
// hab_evt_if: event input channel
// Valid/ready channel carrying the helicity cosines, azimuth and selector.
// ============================================================================
interface hab_evt_if;
    import hab_pkg::*;

    logic  valid;
    logic  ready;
    cos_t  cos_kaon;
    cos_t  cos_muon;
    ang_t  azimuth;
    mode_t mode;

    modport source (output valid, cos_kaon, cos_muon, azimuth, mode, input ready);
    modport sink   (input valid, cos_kaon, cos_muon, azimuth, mode, output ready);
endinterface

### design/hab_res_if.sv
// ============================================================================
// hab_res_if: result output channel
// Valid/ready channel carrying the selected term value and the bad flag.
// ============================================================================
interface hab_res_if;
    import hab_pkg::*;

    logic        valid;
    logic        ready;
    logic signed [17:0] term_value;
    logic        bad_selector;

    modport source (output valid, term_value, bad_selector, input ready);
    modport sink   (input valid, term_value, bad_selector, output ready);
endinterface

### design/helicity_angular_basis_top.sv
// ============================================================================
// helicity_angular_basis_top: angular basis function evaluator
// Derives the helicity sines and azimuth sine/cosine, then returns the
// selected angular basis term in Q2.16 with saturation.
// ============================================================================
// Throughput: one beat per cycle unless the output stalls; every stage
// holds one event. The front-end depth is set by the CORDIC rotation chain
// (one step per stage) and the square-root chain (one result bit per stage)
// running side by side.
// Reset clears every stage's valid bit at once; no clearing pass follows.
module helicity_angular_basis_top #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic      clk,
    input  logic      rst_n,
    hab_evt_if.sink   evt,
    hab_res_if.source res
);
    import hab_pkg::*;

    // The whole pipeline moves together: it advances whenever the output
    // register is empty or its beat is being taken this cycle. The output
    // register therefore acts as the parting stage between the two sides.
    logic   adv;
    logic   out_v;
    evt_t   evt_d;
    trig_t  trig_t_w;

    assign adv       = !out_v || res.ready;
    assign evt.ready = adv;

    always_comb
    begin
        evt_d.cos_kaon = evt.cos_kaon;
        evt_d.cos_muon = evt.cos_muon;
        evt_d.azimuth  = evt.azimuth;
        evt_d.mode     = evt.mode;
    end

    // Front end: both square roots and the rotation CORDIC.
    hab_trig #(
        .STEPS (CORDIC_STEPS)
    ) u_trig (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .in_v  (evt.valid),
        .in_d  (evt_d),
        .out_t (trig_t_w)
    );

    // Back end: product layers, term selection, scaling and saturation.
    hab_terms u_terms (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_t         (trig_t_w),
        .v_out        (out_v),
        .term_value   (res.term_value),
        .bad_selector (res.bad_selector)
    );

    assign res.valid = out_v;

endmodule

### design/hab_trig.sv
// ============================================================================
// hab_trig: sine and azimuth rotation pipeline
// Per register stage, at most one bit of each square root and one CORDIC rotation.
// ============================================================================
module hab_trig #(
    parameter int STEPS = 18
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_v,
    input  hab_pkg::evt_t  in_d,
    output hab_pkg::trig_t out_t
);
    import hab_pkg::*;

    localparam int NSTG = (SQ_BITS + 1 > STEPS + 2) ? SQ_BITS + 1 : STEPS + 2;
    localparam int RS   = 30 - FRAC_BITS;
    localparam longint unsigned ROOT = gain_root(STEPS);
    localparam longint unsigned KVAL = ((64'd1 << 61) + ROOT / 2) / ROOT;

    typedef struct packed {
        evt_t               e;
        logic [34:0]        rk;
        logic [34:0]        rl;
        sin_t               qk;
        sin_t               ql;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } stg_t;

    logic v_reg [NSTG];
    stg_t d_reg [NSTG];

    function automatic logic [34:0] sq_init(input cos_t c);
        logic signed [35:0] sq;
        sq = c * c;
        if (c >= cos_t'(1 << FRAC_BITS) || c <= -cos_t'(1 << FRAC_BITS)) begin
            return 35'd0;
        end
        return 35'((36'sd1 <<< (2 * FRAC_BITS)) - sq);
    endfunction

    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_stg
            localparam int B = (s >= 1 && s <= SQ_BITS) ? SQ_BITS - s : 0;
            localparam int I = (s >= 1 && s <= STEPS) ? s - 1 : 0;
            stg_t d_next;
            logic v_prev;

            if (s == 0) begin : g_src0
                assign v_prev = in_v;
            end else begin : g_srcn
                assign v_prev = v_reg[s-1];
            end

            always_comb
            begin
                logic signed [16:0] a;
                logic [34:0] trk;
                logic [34:0] trl;
                logic signed [33:0] xr;
                logic signed [33:0] yr;
                a = '0;
                trk = '0;
                trl = '0;
                xr = '0;
                yr = '0;
                if (s == 0) begin
                    d_next.e    = in_d;
                    d_next.rk   = sq_init(in_d.cos_kaon);
                    d_next.rl   = sq_init(in_d.cos_muon);
                    d_next.qk   = '0;
                    d_next.ql   = '0;
                    d_next.x    = 34'(KVAL);
                    d_next.y    = '0;
                    d_next.flip = 1'b0;
                    a = 17'(in_d.azimuth);
                    if (in_d.azimuth > 16'sd16384) begin
                        a = a - 17'sd32768;
                        d_next.flip = 1'b1;
                    end else if (in_d.azimuth < -16'sd16384) begin
                        a = a + 17'sd32768;
                        d_next.flip = 1'b1;
                    end
                    d_next.z = 34'(a) <<< 16;
                end else begin
                    d_next = d_reg[s-1];
                    if (s <= SQ_BITS) begin
                        trk = (35'(d_next.qk) << (B + 1)) + (35'd1 << (2 * B));
                        trl = (35'(d_next.ql) << (B + 1)) + (35'd1 << (2 * B));
                        if (d_next.rk >= trk) begin
                            d_next.rk = d_next.rk - trk;
                            d_next.qk = d_next.qk | (sin_t'(1) << B);
                        end
                        if (d_next.rl >= trl) begin
                            d_next.rl = d_next.rl - trl;
                            d_next.ql = d_next.ql | (sin_t'(1) << B);
                        end
                    end
                    if (s <= STEPS) begin
                        if (d_next.z >= 0) begin
                            xr = d_next.x - (d_next.y >>> I);
                            yr = d_next.y + (d_next.x >>> I);
                            d_next.z = d_next.z - 34'(ATAN_TAB[I]);
                        end else begin
                            xr = d_next.x + (d_next.y >>> I);
                            yr = d_next.y - (d_next.x >>> I);
                            d_next.z = d_next.z + 34'(ATAN_TAB[I]);
                        end
                        d_next.x = xr;
                        d_next.y = yr;
                    end else if (s == STEPS + 1) begin
                        xr = (d_next.x + (34'sd1 <<< (RS - 1))) >>> RS;
                        yr = (d_next.y + (34'sd1 <<< (RS - 1))) >>> RS;
                        if (xr > 34'(ONE_V)) xr = 34'(ONE_V);
                        if (xr < -34'(ONE_V)) xr = -34'(ONE_V);
                        if (yr > 34'(ONE_V)) yr = 34'(ONE_V);
                        if (yr < -34'(ONE_V)) yr = -34'(ONE_V);
                        if (d_next.flip) begin
                            xr = -xr;
                            yr = -yr;
                        end
                        d_next.x = xr;
                        d_next.y = yr;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    v_reg[s] <= 1'b0;
                end else if (adv) begin
                    v_reg[s] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv) begin
                    d_reg[s] <= d_next;
                end
            end
        end
    endgenerate

    always_comb
    begin
        out_t.v    = v_reg[NSTG-1];
        out_t.mode = d_reg[NSTG-1].e.mode;
        out_t.ck   = d_reg[NSTG-1].e.cos_kaon;
        out_t.cl   = d_reg[NSTG-1].e.cos_muon;
        out_t.sk   = d_reg[NSTG-1].qk;
        out_t.sl   = d_reg[NSTG-1].ql;
        out_t.cp   = d_reg[NSTG-1].x[17:0];
        out_t.sp   = d_reg[NSTG-1].y[17:0];
    end

endmodule

### design/hab_terms.sv
// ============================================================================
// hab_terms: basis function product pipeline
// Forms the products layer by layer, selects the term, scales and saturates.
// ============================================================================
module hab_terms (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  hab_pkg::trig_t     in_t,
    output logic               v_out,
    output logic signed [17:0] term_value,
    output logic               bad_selector
);
    import hab_pkg::*;

    // Layer 1
    logic  v1_reg;
    mode_t m1_reg;
    val_t  ck1_reg, sk1_reg, cp1_reg, sp1_reg;
    val_t  ck2_reg, sk2_reg, sl2_reg, skck_reg, slcl_reg, spcp_reg, cp2_reg, sp2_reg;
    // Layer 2
    logic  v2_reg;
    mode_t m2_reg;
    val_t  cp_2_reg, sp_2_reg, sk2_2_reg, spcp_2_reg, sl2_2_reg;
    val_t  t1_reg, omb2_reg, omb3_reg, sksl_reg, q_reg, r_reg, t10a_reg;
    // Layer 3
    logic  v3_reg;
    mode_t m3_reg;
    val_t  t1_3_reg, sl2_3_reg, t10a_3_reg;
    val_t  a2_reg, a3_reg, t4_reg, a5_reg, a6_reg, a8_reg, a9_reg;
    // Selection
    logic  v4_reg;
    logic  bad4_reg;
    logic  neg4_reg;
    val_t  op4_reg;
    coef_t cf4_reg;
    // Output
    logic  v5_reg;
    logic  bad5_reg;
    logic signed [17:0] tv5_reg;

    logic  bad4_next;
    logic  neg4_next;
    val_t  op4_next;
    coef_t cf4_next;
    logic signed [VAL_W+COEF_W:0] f5;
    logic signed [17:0] tv5_next;

    always_comb
    begin
        bad4_next = 1'b0;
        neg4_next = 1'b0;
        op4_next  = '0;
        cf4_next  = K_UNITY;
        unique case (m3_reg)
            TERM_1:  op4_next = t1_3_reg;
            TERM_2:  begin op4_next = a2_reg; cf4_next = K_HALF; end
            TERM_3:  begin op4_next = a3_reg; cf4_next = K_HALF; end
            TERM_4:  op4_next = t4_reg;
            TERM_5:  begin op4_next = a5_reg; cf4_next = K_SQRT2; end
            TERM_6:  begin op4_next = a6_reg; cf4_next = K_SQRT2; neg4_next = 1'b1; end
            TERM_7:  begin op4_next = sl2_3_reg; cf4_next = K_THIRD; end
            TERM_8:  begin op4_next = a8_reg; cf4_next = K_2SQRT6; end
            TERM_9:  begin op4_next = a9_reg; cf4_next = K_2SQRT6; neg4_next = 1'b1; end
            TERM_10: begin op4_next = t10a_3_reg; cf4_next = K_2SQRT3; end
            default: bad4_next = 1'b1;
        endcase
    end

    always_comb
    begin
        f5 = mulc(op4_reg, cf4_reg);
        if (neg4_reg) begin
            f5 = -f5;
        end
        if (f5 > (VAL_W+COEF_W+1)'(131071)) begin
            tv5_next = 18'sd131071;
        end else if (f5 < -(VAL_W+COEF_W+1)'(131072)) begin
            tv5_next = -18'sd131072;
        end else begin
            tv5_next = f5[17:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_t.v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            m1_reg   <= in_t.mode;
            ck1_reg  <= val_t'(in_t.ck);
            sk1_reg  <= val_t'({1'b0, in_t.sk});
            cp1_reg  <= val_t'(in_t.cp);
            sp1_reg  <= val_t'(in_t.sp);
            ck2_reg  <= mul(val_t'(in_t.ck), val_t'(in_t.ck));
            sk2_reg  <= mul(val_t'({1'b0, in_t.sk}), val_t'({1'b0, in_t.sk}));
            sl2_reg  <= mul(val_t'({1'b0, in_t.sl}), val_t'({1'b0, in_t.sl}));
            skck_reg <= mul(val_t'({1'b0, in_t.sk}), val_t'(in_t.ck));
            slcl_reg <= mul(val_t'({1'b0, in_t.sl}), val_t'(in_t.cl));
            spcp_reg <= mul(val_t'(in_t.sp), val_t'(in_t.cp));
            cp2_reg  <= mul(val_t'(in_t.cp), val_t'(in_t.cp));
            sp2_reg  <= mul(val_t'(in_t.sp), val_t'(in_t.sp));

            m2_reg     <= m1_reg;
            cp_2_reg   <= cp1_reg;
            sp_2_reg   <= sp1_reg;
            sk2_2_reg  <= sk2_reg;
            spcp_2_reg <= spcp_reg;
            sl2_2_reg  <= sl2_reg;
            t1_reg     <= mul(ck2_reg, sl2_reg);
            omb2_reg   <= ONE_V - mul(cp2_reg, sl2_reg);
            omb3_reg   <= ONE_V - mul(sp2_reg, sl2_reg);
            sksl_reg   <= mul(sk2_reg, sl2_reg);
            q_reg      <= mul(skck_reg, slcl_reg);
            r_reg      <= mul(sk1_reg, slcl_reg);
            t10a_reg   <= mul(ck1_reg, sl2_reg);

            m3_reg     <= m2_reg;
            t1_3_reg   <= t1_reg;
            sl2_3_reg  <= sl2_2_reg;
            t10a_3_reg <= t10a_reg;
            a2_reg     <= mul(sk2_2_reg, omb2_reg);
            a3_reg     <= mul(sk2_2_reg, omb3_reg);
            t4_reg     <= mul(sksl_reg, spcp_2_reg);
            a5_reg     <= mul(q_reg, cp_2_reg);
            a6_reg     <= mul(q_reg, sp_2_reg);
            a8_reg     <= mul(r_reg, cp_2_reg);
            a9_reg     <= mul(r_reg, sp_2_reg);

            bad4_reg <= bad4_next;
            neg4_reg <= neg4_next;
            op4_reg  <= op4_next;
            cf4_reg  <= cf4_next;

            bad5_reg <= bad4_reg;
            tv5_reg  <= tv5_next;
        end
    end

    assign v_out        = v5_reg;
    assign term_value   = tv5_reg;
    assign bad_selector = bad5_reg;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for helicity_angular_basis_top
// Drives event beats with random idling, predicts each term value from the
// helicity sines and a bit-exact CORDIC of the azimuth, and checks the results
// in order against a queue of expected beats.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hab_pkg::*;

    localparam int STEPS     = 18;
    localparam int LATENCY   = 25;
    localparam int CYCLE_CAP = 400000;

    typedef struct {
        logic signed [17:0] term_value;
        logic               bad_selector;
    } term_beat_t;

    logic clk;
    logic rst_n;
    int   fail_count = 0;
    int   cycle_count = 0;
    bit   no_idle;      // when set, neither side idles
    term_beat_t term_queue[$];

    hab_evt_if evt ();
    hab_res_if res ();

    helicity_angular_basis_top #(.CORDIC_STEPS(STEPS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt.sink),
        .res   (res.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Rounding arithmetic shift right: adds half an LSB, then shifts with floor.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return round_shift(a * b, FRAC_BITS);
    endfunction

    function automatic longint fx_mulk(input longint a, input longint k);
        return round_shift(a * k, 30);
    endfunction

    // Integer square root by the bitwise method.
    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint helicity_sine(input longint c);
        longint one;
        one = longint'(1) <<< FRAC_BITS;
        if (c >= one || c <= -one) return 0;
        return longint'(int_root(longint'(one * one - c * c)));
    endfunction

    function automatic longint unit_clamp(input longint v);
        longint one;
        one = longint'(1) <<< FRAC_BITS;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    // Rotation CORDIC of the azimuth; the angle is folded into the right half
    // plane first and both outputs negated when a fold took place.
    task automatic azimuth_sincos(input longint a, output longint sn, output longint cs);
        longint unsigned p;
        longint unsigned root;
        longint x;
        longint y;
        longint z;
        longint t;
        bit flip;
        p = 64'd1 << 62;
        for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
        root = int_root(p);
        x = longint'(((64'd1 << 61) + root / 2) / root);
        y = 0;
        flip = 1'b0;
        if (a > 16384) begin
            a = a - 32768;
            flip = 1'b1;
        end else if (a < -16384) begin
            a = a + 32768;
            flip = 1'b1;
        end
        z = a * 65536;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_TAB[i]);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_TAB[i]);
            end
            x = t;
        end
        x = unit_clamp(round_shift(x, 30 - FRAC_BITS));
        y = unit_clamp(round_shift(y, 30 - FRAC_BITS));
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = x;
        sn = y;
    endtask

    task automatic predict_term(input evt_t e, output term_beat_t r);
        longint one;
        longint ck;
        longint cl;
        longint sk;
        longint sl;
        longint sp;
        longint cp;
        longint sl2;
        longint f;
        one = longint'(1) <<< FRAC_BITS;
        ck = longint'(e.cos_kaon);
        cl = longint'(e.cos_muon);
        sk = helicity_sine(ck);
        sl = helicity_sine(cl);
        azimuth_sincos(longint'(e.azimuth), sp, cp);
        sl2 = fx_mul(sl, sl);
        r.bad_selector = 1'b0;
        case (e.mode)
            TERM_1:  f = fx_mul(fx_mul(ck, ck), sl2);
            TERM_2:  f = fx_mulk(fx_mul(fx_mul(sk, sk), one - fx_mul(fx_mul(cp, cp), sl2)),
                                 K_HALF);
            TERM_3:  f = fx_mulk(fx_mul(fx_mul(sk, sk), one - fx_mul(fx_mul(sp, sp), sl2)),
                                 K_HALF);
            TERM_4:  f = fx_mul(fx_mul(fx_mul(sk, sk), sl2), fx_mul(sp, cp));
            TERM_5:  f = fx_mulk(fx_mul(fx_mul(fx_mul(sk, ck), fx_mul(sl, cl)), cp), K_SQRT2);
            TERM_6:  f = -fx_mulk(fx_mul(fx_mul(fx_mul(sk, ck), fx_mul(sl, cl)), sp), K_SQRT2);
            TERM_7:  f = fx_mulk(sl2, K_THIRD);
            TERM_8:  f = fx_mulk(fx_mul(fx_mul(sk, fx_mul(sl, cl)), cp), K_2SQRT6);
            TERM_9:  f = -fx_mulk(fx_mul(fx_mul(sk, fx_mul(sl, cl)), sp), K_2SQRT6);
            TERM_10: f = fx_mulk(fx_mul(ck, sl2), K_2SQRT3);
            default:
            begin
                f = 0;
                r.bad_selector = 1'b1;
            end
        endcase
        if (f > 131071) f = 131071;
        if (f < -131072) f = -131072;
        r.term_value = f[17:0];
    endtask

    // Sends one event beat. The valid line is changed only at falling edges
    // and stays high across back-to-back beats; an idle gap drops it low.
    task automatic send_event(input evt_t e);
        term_beat_t r;
        if (!no_idle) begin
            while ($urandom_range(99) < 9) begin
                evt.valid <= 1'b0;
                @(negedge clk);
            end
        end
        evt.valid    <= 1'b1;
        evt.cos_kaon <= e.cos_kaon;
        evt.cos_muon <= e.cos_muon;
        evt.azimuth  <= e.azimuth;
        evt.mode     <= e.mode;
        predict_term(e, r);
        @(posedge clk);
        while (!evt.ready) @(posedge clk);
        term_queue.push_back(r);
        @(negedge clk);
    endtask

    function automatic logic signed [17:0] random_cos();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 18'sd65536;
        if (k == 1) return -18'sd65536;
        if (k == 2) return 18'($urandom());   // the whole field, beyond one too
        return 18'(int'($urandom_range(131072)) - 65536);
    endfunction

    function automatic evt_t random_event(input bit valid_mode);
        evt_t e;
        e.cos_kaon = random_cos();
        e.cos_muon = random_cos();
        e.azimuth  = ang_t'($urandom());
        e.mode     = valid_mode ? mode_t'($urandom_range(10, 1)) : mode_t'($urandom());
        return e;
    endfunction

    task automatic wait_drained();
        evt.valid <= 1'b0;
        while (term_queue.size() != 0) @(negedge clk);
    endtask

    // Field extremes, the unit and beyond-unit cosines, and the folding
    // boundaries of the azimuth, across every term.
    task automatic test_directed();
        evt_t e;
        logic signed [17:0] cvals[6];
        logic signed [15:0] avals[6];
        cvals = '{18'sd0, 18'sd65536, -18'sd65536, 18'sd131071, -18'sd131072, 18'sd46341};
        avals = '{16'sd0, 16'sd16384, 16'sd16385, -16'sd16385, 16'sd32767, -16'sd32768};
        for (int m = 0; m < 16; m++) begin
            e.cos_kaon = cvals[m % 6];
            e.cos_muon = cvals[(m + 3) % 6];
            e.azimuth  = avals[m % 6];
            e.mode     = mode_t'(m);
            send_event(e);
        end
        // Two small cosines of opposite sign at the lower azimuth fold boundary, terms 5 and 9.
        e = '{cos_kaon: 18'sd1, cos_muon: -18'sd1, azimuth: -16'sd16384, mode: TERM_5};
        send_event(e);
        e.mode = TERM_9;
        send_event(e);
    endtask

    // Mostly valid selectors with random angles; one in eight draws from the whole field.
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_event(random_event($urandom_range(7) != 0));
        end
    endtask

    // Holds off until every expected beat has come, then bursts with no idling.
    task automatic test_pause_and_burst();
        wait_drained();
        no_idle = 1'b1;
        test_random(150);
        no_idle = 1'b0;
    endtask

    // Result side: ready idles at random outside no_idle; beats are checked in order.
    always @(negedge clk) begin
        if (!rst_n) res.ready <= 1'b0;
        else res.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);
    end

    always @(posedge clk) begin
        term_beat_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && res.valid && res.ready) begin
            if (term_queue.size() == 0) begin
                $error("result beat with nothing expected: term_value %0d",
                       res.term_value);
                fail_count = fail_count + 1;
            end else begin
                want = term_queue.pop_front();
                if (res.term_value !== want.term_value) begin
                    $error("term_value expected %0d actual %0d",
                           want.term_value, res.term_value);
                    fail_count = fail_count + 1;
                end
                if (res.bad_selector !== want.bad_selector) begin
                    $error("bad_selector expected %0d actual %0d",
                           want.bad_selector, res.bad_selector);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        if (cycle_count >= CYCLE_CAP) begin
            $display("helicity_angular_basis_top test failed");
            $finish;
        end
    end

    initial begin
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        evt.valid    = 1'b0;
        evt.cos_kaon = '0;
        evt.cos_muon = '0;
        evt.azimuth  = '0;
        evt.mode     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(300);
        test_pause_and_burst();
        test_random(280);

        wait_drained();
        repeat (LATENCY + 5) @(negedge clk);
        if (fail_count == 0 && term_queue.size() == 0) begin
            $display("helicity_angular_basis_top test passed");
        end else begin
            $display("helicity_angular_basis_top test failed");
        end
        $finish;
    end
endmodule
